[rtl/tga_rle_pkg.sv]
// ----------------------------------------------------------------------------
// TGA RLE decoder package
// Shared types and constants for the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

  // Header layout
  localparam int unsigned HdrCntW      = 5;
  localparam logic [HdrCntW-1:0] HdrTypeIdx   = 5'd2;
  localparam logic [HdrCntW-1:0] HdrTmplLen   = 5'd12;
  localparam logic [HdrCntW-1:0] HdrWidthLo   = 5'd12;
  localparam logic [HdrCntW-1:0] HdrWidthHi   = 5'd13;
  localparam logic [HdrCntW-1:0] HdrHeightLo  = 5'd14;
  localparam logic [HdrCntW-1:0] HdrHeightHi  = 5'd15;
  localparam logic [HdrCntW-1:0] HdrDepthIdx  = 5'd16;
  localparam logic [HdrCntW-1:0] HdrLastIdx   = 5'd17;

  localparam logic [7:0] ImgTypeRle    = 8'd10;
  localparam logic [7:0] ImgTypeRaw    = 8'd2;
  localparam logic [7:0] DepthRgb      = 8'd24;
  localparam logic [7:0] DepthRgba     = 8'd32;
  localparam logic [7:0] RunPktOffset  = 8'd127;

  // Decoder phase, one-hot
  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_PACKET = 4'b0010,
    PH_PIXEL  = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_PIXELS     = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_UNCOMP     = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] repeat_res;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_data_t;

endpackage

[rtl/tga_rle_pixel_decoder.sv]
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder
// Checks the 18-byte TGA header and decodes type-10 packets into RGBA pixels.
// ----------------------------------------------------------------------------
// A result is registered and shows on the master side in the cycle after the
// byte that completes it is taken. The input takes one byte per cycle and
// stalls only while the output register holds a result that has not been taken.
// Reset (rst_ni low, asynchronous) returns the decoder to header byte 0 and
// empties the output register; tuser on the slave side restarts a file.
module tga_rle_pixel_decoder
  import tga_rle_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] first_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // red, green, blue, alpha, repeat_res
  output logic        m_axis_tlast,   // image_end
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  phase_e              phase_q, phase_d, ph_cur;
  logic [HdrCntW-1:0]  hdr_cnt_q, hdr_cnt_d, hdr_cnt_cur;
  logic                mismatch_q, mismatch_d, mismatch_cur;
  logic                uncomp_q, uncomp_d, uncomp_cur;
  logic [15:0]         width_q, width_d, width_cur;
  logic [15:0]         height_q, height_d, height_cur;
  logic                has_alpha_q, has_alpha_d, has_alpha_cur;
  logic [31:0]         pix_left_q, pix_left_d, pix_left_cur;
  logic [7:0]          pkt_left_q, pkt_left_d, pkt_left_cur;
  logic                pkt_run_q, pkt_run_d, pkt_run_cur;
  logic [1:0]          byte_idx_q, byte_idx_d, byte_idx_cur;
  logic [23:0]         pix_bytes_q, pix_bytes_d, pix_bytes_cur;

  logic                out_vld_q, out_vld_d;
  pix_data_t           out_data_q, res_data;
  logic                out_last_q, res_last;
  status_e             out_stat_q, res_stat;
  logic                emit;
  logic                accept;

  logic [7:0]          b;
  logic [31:0]         area;
  logic [31:0]         rep;
  logic [31:0]         left_after;
  logic                last_byte;
  logic [23:0]         pb_new;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign area          = {16'd0, width_q} * {16'd0, height_q};

  always_comb begin
    // a first_byte request starts from the reset state
    if (s_axis_tuser) begin
      ph_cur        = PH_HEADER;
      hdr_cnt_cur   = '0;
      mismatch_cur  = 1'b0;
      uncomp_cur    = 1'b0;
      width_cur     = '0;
      height_cur    = '0;
      has_alpha_cur = 1'b0;
      pix_left_cur  = '0;
      pkt_left_cur  = '0;
      pkt_run_cur   = 1'b0;
      byte_idx_cur  = '0;
      pix_bytes_cur = '0;
    end else begin
      ph_cur        = phase_q;
      hdr_cnt_cur   = hdr_cnt_q;
      mismatch_cur  = mismatch_q;
      uncomp_cur    = uncomp_q;
      width_cur     = width_q;
      height_cur    = height_q;
      has_alpha_cur = has_alpha_q;
      pix_left_cur  = pix_left_q;
      pkt_left_cur  = pkt_left_q;
      pkt_run_cur   = pkt_run_q;
      byte_idx_cur  = byte_idx_q;
      pix_bytes_cur = pix_bytes_q;
    end

    phase_d     = ph_cur;
    hdr_cnt_d   = hdr_cnt_cur;
    mismatch_d  = mismatch_cur;
    uncomp_d    = uncomp_cur;
    width_d     = width_cur;
    height_d    = height_cur;
    has_alpha_d = has_alpha_cur;
    pix_left_d  = pix_left_cur;
    pkt_left_d  = pkt_left_cur;
    pkt_run_d   = pkt_run_cur;
    byte_idx_d  = byte_idx_cur;
    pix_bytes_d = pix_bytes_cur;

    emit     = 1'b0;
    res_data = '0;
    res_last = 1'b0;
    res_stat = ST_PIXELS;

    pb_new = pix_bytes_cur;
    case (byte_idx_cur)
      2'd0:    pb_new[7:0]   = pix_bytes_cur[7:0]   | b;
      2'd1:    pb_new[15:8]  = pix_bytes_cur[15:8]  | b;
      2'd2:    pb_new[23:16] = pix_bytes_cur[23:16] | b;
      default: pb_new        = pix_bytes_cur;
    endcase
    last_byte  = has_alpha_cur ? (byte_idx_cur == 2'd3) : (byte_idx_cur == 2'd2);
    rep        = pkt_run_cur ? {24'd0, pkt_left_cur} : 32'd1;
    if (rep > pix_left_cur) begin
      rep = pix_left_cur;
    end
    left_after = pix_left_cur - rep;

    case (ph_cur)
      PH_HEADER: begin
        if (hdr_cnt_cur < HdrTmplLen) begin
          if (hdr_cnt_cur == HdrTypeIdx) begin
            if (b == ImgTypeRaw) begin
              uncomp_d = 1'b1;
            end else if (b != ImgTypeRle) begin
              mismatch_d = 1'b1;
            end
          end else if (b != 8'd0) begin
            mismatch_d = 1'b1;
          end
        end else if (hdr_cnt_cur == HdrWidthLo) begin
          width_d = {8'd0, b};
        end else if (hdr_cnt_cur == HdrWidthHi) begin
          width_d = {b, width_cur[7:0]};
        end else if (hdr_cnt_cur == HdrHeightLo) begin
          height_d = {8'd0, b};
        end else if (hdr_cnt_cur == HdrHeightHi) begin
          height_d = {b, height_cur[7:0]};
        end else if (hdr_cnt_cur == HdrDepthIdx) begin
          if (b == DepthRgba) begin
            has_alpha_d = 1'b1;
          end else if (b != DepthRgb) begin
            mismatch_d = 1'b1;
          end
        end
        if (hdr_cnt_cur < HdrLastIdx) begin
          hdr_cnt_d = hdr_cnt_cur + HdrCntW'(1);
        end else if (mismatch_cur) begin
          phase_d  = PH_DONE;
          emit     = 1'b1;
          res_stat = ST_BAD_HEADER;
        end else if (uncomp_cur) begin
          phase_d  = PH_DONE;
          emit     = 1'b1;
          res_stat = ST_UNCOMP;
        end else begin
          // width and height are settled by header byte 17, never the first byte
          pix_left_d = area;
          phase_d    = (area == 32'd0) ? PH_DONE : PH_PACKET;
        end
      end
      PH_PACKET: begin
        if (!b[7]) begin
          pkt_run_d  = 1'b0;
          pkt_left_d = b + 8'd1;
        end else begin
          pkt_run_d  = 1'b1;
          pkt_left_d = b - RunPktOffset;
        end
        byte_idx_d  = '0;
        pix_bytes_d = '0;
        phase_d     = PH_PIXEL;
      end
      PH_PIXEL: begin
        if (!last_byte) begin
          pix_bytes_d = pb_new;
          byte_idx_d  = byte_idx_cur + 2'd1;
        end else begin
          emit                = 1'b1;
          res_data.red        = pb_new[23:16];
          res_data.green      = pb_new[15:8];
          res_data.blue       = pb_new[7:0];
          res_data.alpha      = has_alpha_cur ? b : 8'd0;
          res_data.repeat_res = rep[7:0];
          res_last            = (left_after == 32'd0);
          pix_left_d          = left_after;
          byte_idx_d          = '0;
          pix_bytes_d         = '0;
          if (pkt_run_cur) begin
            pkt_left_d = '0;
          end else if (pkt_left_cur != 8'd0) begin
            pkt_left_d = pkt_left_cur - 8'd1;
          end
          if (left_after == 32'd0) begin
            phase_d = PH_DONE;
          end else if (pkt_left_d == 8'd0) begin
            phase_d = PH_PACKET;
          end
        end
      end
      PH_DONE: begin
        phase_d = PH_DONE;
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase

    if (accept) begin
      out_vld_d = emit;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_cnt_q   <= '0;
      mismatch_q  <= 1'b0;
      uncomp_q    <= 1'b0;
      width_q     <= '0;
      height_q    <= '0;
      has_alpha_q <= 1'b0;
      pix_left_q  <= '0;
      pkt_left_q  <= '0;
      pkt_run_q   <= 1'b0;
      byte_idx_q  <= '0;
      pix_bytes_q <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (accept) begin
        phase_q     <= phase_d;
        hdr_cnt_q   <= hdr_cnt_d;
        mismatch_q  <= mismatch_d;
        uncomp_q    <= uncomp_d;
        width_q     <= width_d;
        height_q    <= height_d;
        has_alpha_q <= has_alpha_d;
        pix_left_q  <= pix_left_d;
        pkt_left_q  <= pkt_left_d;
        pkt_run_q   <= pkt_run_d;
        byte_idx_q  <= byte_idx_d;
        pix_bytes_q <= pix_bytes_d;
      end
    end
  end

  // output payload, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_data_q <= res_data;
      out_last_q <= res_last;
      out_stat_q <= res_stat;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_stat_q;

endmodule

[test/tb_tga_rle_pixel_decoder.sv]
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder testbench
// Feeds TGA byte streams through the slave stream port. The streams are
// mostly well-formed type-10 files with random packets and pixels, and the
// rest are bad templates, bad depths, type-2 files, empty and cut-off images.
// A behavioral decoder predicts every pixel or status request, and the
// master side is checked against it in order while both ends idle at random.
// ----------------------------------------------------------------------------
module tb_tga_rle_pixel_decoder
  import tga_rle_pkg::*;
();

  localparam int CycleLimit = 300000;
  localparam int RandomBytes = 750;

  typedef struct {
    logic [7:0] data;
    logic       first;
  } file_byte_t;

  typedef struct {
    pix_data_t pix;
    logic      last;
    status_e   st;
  } pixel_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;

  file_byte_t byte_q[$];
  pixel_res_t pixel_exp_q[$];
  int         errors = 0;
  int         cycles = 0;

  // decoder state mirror
  phase_e      dec_phase;
  logic [4:0]  hdr_idx;
  logic        hdr_bad;
  logic        hdr_uncomp;
  logic        hdr_alpha;
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic [31:0] pix_left;
  logic [7:0]  pkt_left;
  logic        pkt_run;
  logic [1:0]  byte_idx;
  logic [23:0] bgr;

  tga_rle_pixel_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic clear_decoder();
    dec_phase  = PH_HEADER;
    hdr_idx    = '0;
    hdr_bad    = 1'b0;
    hdr_uncomp = 1'b0;
    hdr_alpha  = 1'b0;
    img_w      = '0;
    img_h      = '0;
    pix_left   = '0;
    pkt_left   = '0;
    pkt_run    = 1'b0;
    byte_idx   = '0;
    bgr        = '0;
  endtask

  // Advance the decoder mirror by one byte; queue any request it produces.
  task automatic decode_byte(input logic [7:0] b, input logic first);
    pixel_res_t res;
    logic [31:0] rep;
    logic [2:0]  need;
    res.pix  = '0;
    res.last = 1'b0;
    res.st   = ST_PIXELS;
    if (first) clear_decoder();
    case (dec_phase)
      PH_HEADER: begin
        if (hdr_idx < HdrTmplLen) begin
          if (hdr_idx == HdrTypeIdx) begin
            if (b == ImgTypeRaw) hdr_uncomp = 1'b1;
            else if (b != ImgTypeRle) hdr_bad = 1'b1;
          end else if (b != 8'h00) begin
            hdr_bad = 1'b1;
          end
        end else if (hdr_idx == HdrWidthLo) begin
          img_w = {8'h00, b};
        end else if (hdr_idx == HdrWidthHi) begin
          img_w[15:8] = b;
        end else if (hdr_idx == HdrHeightLo) begin
          img_h = {8'h00, b};
        end else if (hdr_idx == HdrHeightHi) begin
          img_h[15:8] = b;
        end else if (hdr_idx == HdrDepthIdx) begin
          if (b == DepthRgba) hdr_alpha = 1'b1;
          else if (b != DepthRgb) hdr_bad = 1'b1;
        end
        if (hdr_idx < HdrLastIdx) begin
          hdr_idx = hdr_idx + 5'd1;
        end else if (hdr_bad) begin
          dec_phase = PH_DONE;
          res.st = ST_BAD_HEADER;
          pixel_exp_q.push_back(res);
        end else if (hdr_uncomp) begin
          dec_phase = PH_DONE;
          res.st = ST_UNCOMP;
          pixel_exp_q.push_back(res);
        end else begin
          pix_left = {16'h0000, img_w} * {16'h0000, img_h};
          dec_phase = (pix_left == 0) ? PH_DONE : PH_PACKET;
        end
      end
      PH_PACKET: begin
        if (b < 8'd128) begin
          pkt_run  = 1'b0;
          pkt_left = b + 8'd1;
        end else begin
          pkt_run  = 1'b1;
          pkt_left = b - RunPktOffset;
        end
        byte_idx  = '0;
        bgr       = '0;
        dec_phase = PH_PIXEL;
      end
      PH_PIXEL: begin
        need = hdr_alpha ? 3'd4 : 3'd3;
        if (byte_idx < 2'd3) bgr[8*byte_idx +: 8] = b;
        if ({1'b0, byte_idx} + 3'd1 < need) begin
          byte_idx = byte_idx + 2'd1;
        end else begin
          rep = pkt_run ? {24'h0, pkt_left} : 32'd1;
          if (rep > pix_left) rep = pix_left;
          pix_left = pix_left - rep;
          res.pix.red        = bgr[23:16];
          res.pix.green      = bgr[15:8];
          res.pix.blue       = bgr[7:0];
          res.pix.alpha      = hdr_alpha ? b : 8'h00;
          res.pix.repeat_res = rep[7:0];
          res.last           = (pix_left == 0);
          pixel_exp_q.push_back(res);
          byte_idx = '0;
          bgr      = '0;
          if (pkt_run) pkt_left = '0;
          else if (pkt_left > 0) pkt_left = pkt_left - 8'd1;
          if (pix_left == 0) dec_phase = PH_DONE;
          else if (pkt_left == 0) dec_phase = PH_PACKET;
        end
      end
      default: ;
    endcase
  endtask

  // Append one random file to the byte stream; returns the number of bytes that
  // the decoder actually acts on.
  task automatic add_file(output int counted);
    logic [7:0] hdr[18];
    logic [7:0] body[$];
    logic [7:0] pkt;
    int         kind, p, lim, np, cut, total, i, j;
    longint     w, h, left;
    bit         alpha, valid, big;
    kind  = $urandom_range(0, 99);
    valid = 1'b1;
    big   = 1'b0;
    for (i = 0; i < 18; i++) hdr[i] = 8'h00;
    hdr[HdrTypeIdx] = ImgTypeRle;
    alpha = $urandom_range(0, 1);
    hdr[HdrDepthIdx] = alpha ? DepthRgba : DepthRgb;
    w = $urandom_range(1, 8);
    h = $urandom_range(1, 8);
    if ($urandom_range(0, 9) == 0) begin
      w = $urandom_range(9, 60);
      h = $urandom_range(1, 3);
    end
    if (kind < 8) begin
      p = $urandom_range(0, 11);
      if (p == HdrTypeIdx) begin
        do hdr[p] = 8'($urandom);
        while (hdr[p] == ImgTypeRle || hdr[p] == ImgTypeRaw);
      end else begin
        hdr[p] = 8'($urandom_range(1, 255));
        // bad template must win over the uncompressed flag
        if ($urandom_range(0, 2) == 0) hdr[HdrTypeIdx] = ImgTypeRaw;
      end
      valid = 1'b0;
    end else if (kind < 14) begin
      do hdr[HdrDepthIdx] = 8'($urandom);
      while (hdr[HdrDepthIdx] == DepthRgb || hdr[HdrDepthIdx] == DepthRgba);
      valid = 1'b0;
    end else if (kind < 20) begin
      hdr[HdrTypeIdx] = ImgTypeRaw;
      valid = 1'b0;
    end else if (kind < 25) begin
      if ($urandom_range(0, 1) == 1) begin
        w = 0;
        h = $urandom_range(0, 65535);
      end else begin
        w = $urandom_range(0, 65535);
        h = 0;
      end
      valid = 1'b0;
    end else if (kind < 28) begin
      big = 1'b1;
      if ($urandom_range(0, 1) == 1) begin
        w = 65535;
        h = 65535;
      end else begin
        w = $urandom_range(256, 65535);
        h = $urandom_range(256, 65535);
      end
    end
    hdr[HdrWidthLo]  = w[7:0];
    hdr[HdrWidthHi]  = w[15:8];
    hdr[HdrHeightLo] = h[7:0];
    hdr[HdrHeightHi] = h[15:8];
    hdr[HdrLastIdx]  = 8'($urandom);

    if (valid) begin
      left = w * h;
      while (left > 0 && body.size() < 300) begin
        if ($urandom_range(0, 1) == 1) begin
          lim = (left < 6) ? int'(left) : 6;
          if ($urandom_range(0, 6) == 0) pkt = 8'($urandom_range(0, 127));
          else pkt = 8'($urandom_range(0, lim - 1));
          np = (pkt + 1 < left) ? pkt + 1 : int'(left);
          left = left - np;
        end else begin
          if ($urandom_range(0, 2) == 0) pkt = 8'($urandom_range(128, 255));
          else pkt = 8'($urandom_range(128, 133));
          np = 1;
          left = (pkt - 127 < left) ? left - (pkt - 127) : 0;
        end
        body.push_back(pkt);
        for (i = 0; i < np * (alpha ? 4 : 3); i++) begin
          p = $urandom_range(0, 7);
          body.push_back(p == 0 ? 8'h00 : p == 1 ? 8'hFF : 8'($urandom));
        end
      end
    end
    total = 18 + body.size();
    counted = total;
    // bytes past the end of the image or after a rejected header are ignored
    for (j = $urandom_range(0, 2); j > 0; j--) body.push_back(8'($urandom));
    cut = 18 + body.size();
    if (valid && !big && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, total - 1);
      counted = cut;
    end
    for (i = 0; i < cut; i++) begin
      byte_q.push_back('{data: (i < 18) ? hdr[i] : body[i-18], first: (i == 0)});
    end
  endtask

  task automatic report_error(input string msg);
    $display("ERROR @%0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_error($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Sender: bursts of random length with random gaps between them.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin : drive_p
    file_byte_t cur;
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready) decode_byte(s_tdata, s_tuser);
      if (!s_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          cur = byte_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= cur.data;
          s_tuser  <= cur.first;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: the ready pattern follows one of four stall modes, picked anew at random.
  int stall_mode = 0;
  int stall_hold = 0;

  always @(posedge clk_i) begin : monitor_p
    pixel_res_t want;
    pix_data_t  got;
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else if (rst_ni) begin
      if (m_axis_tvalid && m_tready) begin
        if (pixel_exp_q.size() == 0) begin
          report_error($sformatf("pixel request %0h with none pending", m_axis_tdata));
        end else begin
          want = pixel_exp_q.pop_front();
          got = m_axis_tdata;
          check_field("red", got.red, want.pix.red);
          check_field("green", got.green, want.pix.green);
          check_field("blue", got.blue, want.pix.blue);
          check_field("alpha", got.alpha, want.pix.alpha);
          check_field("repeat", got.repeat_res, want.pix.repeat_res);
          check_field("image_end", {7'h0, m_axis_tlast}, {7'h0, want.last});
          check_field("status", {6'h0, m_axis_tuser}, {6'h0, want.st});
        end
      end
      if (stall_hold == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_hold = $urandom_range(50, 250);
      end else begin
        stall_hold--;
      end
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= (cycles % 4 == 0);
        default: m_tready <= cycles[4];
      endcase
    end
  end

  initial begin : stim_p
    logic [7:0] directed[$];
    int n, acted;
    clear_decoder();
    // No start flag after reset: 3x1, 24-bit, one raw pixel, then a full-size
    // run clipped to the two pixels left, then a stray byte after the end.
    directed = '{8'h00, 8'h00, ImgTypeRle, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                 8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 8'h01, 8'h00,
                 DepthRgb, 8'hFF,
                 8'h00, 8'h00, 8'hFF, 8'h80,
                 8'hFF, 8'hFF, 8'h00, 8'h7F,
                 8'h55};
    foreach (directed[k]) byte_q.push_back('{data: directed[k], first: 1'b0});
    n = 0;
    while (n < RandomBytes) begin
      add_file(acted);
      n += acted;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (byte_q.size() != 0 || s_tvalid) @(posedge clk_i);
    while (pixel_exp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tga_rle_pkg.sv
rtl/tga_rle_pixel_decoder.sv
test/tb_tga_rle_pixel_decoder.sv
